>>> hdl/scwin_pkg.sv
// scwin_pkg: constants, widths and enum types of the sender congestion window.
// No dependencies; imported by scwin_ram users and the sender_congestion_window top.
`default_nettype none

package scwin_pkg;

   // Transfer limits
   localparam int unsigned MAX_PACKETS  = 1024;
   localparam int unsigned PACKET_BYTES = 1000;
   localparam int unsigned MAX_WINDOW   = 1024;
   localparam int unsigned THRESH_RESET = 16;

   // Field widths
   localparam int unsigned FILE_W  = 20;
   localparam int unsigned SEQ_W   = 11;
   localparam int unsigned WIN_W   = 11;
   localparam int unsigned THR_W   = 10;
   localparam int unsigned BYTES_W = 10;

   // Ack bitmap held as rows of bits in one RAM
   localparam int unsigned ACK_WORD_W = 32;
   localparam int unsigned ACK_ROWS   = MAX_PACKETS / ACK_WORD_W;
   localparam int unsigned ROW_W      = $clog2(ACK_ROWS);
   localparam int unsigned BIT_W      = $clog2(ACK_WORD_W);

   // Packet count by reciprocal multiply: floor(y/PACKET_BYTES) exact for y < 2**21
   localparam int unsigned     DIV_SHIFT = 31;
   localparam longint unsigned DIV_RECIP =
      ((64'd1 << DIV_SHIFT) + PACKET_BYTES - 1) / PACKET_BYTES;
   localparam int unsigned     RECIP_W   = $clog2(DIV_RECIP + 1);
   localparam int unsigned     PROD_W    = FILE_W + 1 + RECIP_W;
   localparam int unsigned     QUOT_W    = PROD_W - DIV_SHIFT;

   typedef enum logic [1:0] {
      CMD_SEND    = 2'd0,
      CMD_ACK     = 2'd1,
      CMD_TIMEOUT = 2'd2,
      CMD_END     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SCAN
   } state_type;

endpackage

`default_nettype wire

>>> hdl/scwin_ram.sv
// scwin_ram: generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module scwin_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/sender_congestion_window.sv
// sender_congestion_window: sequence and window control of a reliable datagram sender.
// Depends on scwin_pkg and scwin_ram (ack bitmap storage).
//
//   channel   handshake             payload
//   request   start / busy          req_cmd, req_ack_seq
//   response  rsp_valid (strobe)    rsp_send_valid .. rsp_all_acked
//   config    csr_wr_en             csr_wr_data (file_bytes)
//
// Steps: send, ack and timeout are accepted with a RAM read, then executed and
//   written back. End of round does the same and, when the round timed out, then
//   scans the ack bitmap: it is read one 32-bit row a cycle, up to 32 rows.
// Reset: a clearing pass zeroes the 32 bitmap rows with busy high;
//   config writes are taken during it.
// Stalls: the response cannot be held off; each item gives one rsp_valid pulse.
`default_nettype none

module sender_congestion_window (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_cmd,
   input  logic [scwin_pkg::SEQ_W-1:0]   req_ack_seq,
   input  logic                          csr_wr_en,
   input  logic [scwin_pkg::FILE_W-1:0]  csr_wr_data,
   output logic                          rsp_valid,
   output logic                          rsp_send_valid,
   output logic [scwin_pkg::SEQ_W-1:0]   rsp_send_seq,
   output logic [scwin_pkg::BYTES_W-1:0] rsp_send_bytes,
   output logic [scwin_pkg::WIN_W-1:0]   rsp_window_size,
   output logic [scwin_pkg::THR_W-1:0]   rsp_slow_start_limit,
   output logic [scwin_pkg::SEQ_W-1:0]   rsp_resume_seq,
   output logic                          rsp_all_acked
);

   import scwin_pkg::*;

   // ---------------------------------------------------------------- config
   // Packet count worked out when file_bytes is written
   logic [FILE_W-1:0] file_bytes_ff;
   logic [SEQ_W-1:0]  pkt_count_ff;
   logic [FILE_W:0]   cnt_round_up;
   logic [PROD_W-1:0] cnt_prod;
   logic [QUOT_W-1:0] cnt_quot;
   logic [SEQ_W-1:0]  pkt_count_in;

   always_comb begin
      cnt_round_up = {1'b0, csr_wr_data} + (FILE_W+1)'(PACKET_BYTES - 1);
      cnt_prod     = PROD_W'(cnt_round_up) * PROD_W'(DIV_RECIP);
      cnt_quot     = cnt_prod[DIV_SHIFT +: QUOT_W];
      if (cnt_quot > QUOT_W'(MAX_PACKETS)) begin
         pkt_count_in = SEQ_W'(MAX_PACKETS);
      end else begin
         pkt_count_in = SEQ_W'(cnt_quot);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         file_bytes_ff <= '0;
         pkt_count_ff  <= '0;
      end else if (csr_wr_en) begin
         file_bytes_ff <= csr_wr_data;
         pkt_count_ff  <= pkt_count_in;
      end
   end

   // ---------------------------------------------------------------- state
   state_type         state_ff, state_in;
   logic [SEQ_W-1:0]  next_seq_ff, next_seq_in;
   logic [WIN_W-1:0]  window_ff, window_in;
   logic [THR_W-1:0]  thresh_ff, thresh_in;
   logic [WIN_W-1:0]  sent_ff, sent_in;
   logic              timed_out_ff, timed_out_in;
   logic              finished_ff, finished_in;
   logic [ROW_W-1:0]  clr_row_ff, clr_row_in;
   logic [ROW_W-1:0]  scan_row_ff, scan_row_in;

   // item held for the execute cycle
   cmd_type           cmd_ff;
   logic [SEQ_W-1:0]  ack_seq_ff;
   logic [FILE_W:0]   offset_ff;

   // response registers
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_send_valid_ff, rsp_send_valid_in;
   logic [SEQ_W-1:0]  rsp_send_seq_ff, rsp_send_seq_in;
   logic [BYTES_W-1:0] rsp_send_bytes_ff, rsp_send_bytes_in;

   // RAM port
   logic                  ram_wr_en;
   logic [ROW_W-1:0]      ram_wr_addr;
   logic [ACK_WORD_W-1:0] ram_wr_data;
   logic [ROW_W-1:0]      ram_rd_addr;
   logic [ACK_WORD_W-1:0] ram_rd_data;

   logic              accept;
   logic [SEQ_W-1:0]  req_ack_idx;
   logic [SEQ_W-1:0]  ack_idx;
   logic              ack_in_range;
   logic [FILE_W:0]   remain;
   logic [WIN_W:0]    grown;
   logic [THR_W-1:0]  half;

   // scan of one bitmap row
   logic [ROW_W:0]        row_ext;
   logic [ROW_W:0]        full_rows;
   logic [ACK_WORD_W-1:0] row_mask;
   logic [ACK_WORD_W-1:0] row_zeros;
   logic [BIT_W-1:0]      first_bit;
   logic [SEQ_W-1:0]      row_end;

   assign accept      = start && !busy;
   assign busy        = (state_ff != ST_IDLE);
   assign req_ack_idx = req_ack_seq - SEQ_W'(1);
   assign ack_idx     = ack_seq_ff - SEQ_W'(1);
   assign ack_in_range = (ack_seq_ff != '0) && (ack_seq_ff <= pkt_count_ff);

   // first unacked bit of the row in flight, limited to the packet count
   always_comb begin
      row_ext   = {1'b0, scan_row_ff};
      full_rows = pkt_count_ff[SEQ_W-1:BIT_W];
      if (row_ext < full_rows) begin
         row_mask = '1;
      end else if (row_ext == full_rows) begin
         row_mask = (ACK_WORD_W'(1) << pkt_count_ff[BIT_W-1:0]) - ACK_WORD_W'(1);
      end else begin
         row_mask = '0;
      end
      row_zeros = ~ram_rd_data & row_mask;
      first_bit = '0;
      for (int j = ACK_WORD_W - 1; j >= 0; j--) begin
         if (row_zeros[j]) begin
            first_bit = BIT_W'(j);
         end
      end
      row_end = {row_ext + (ROW_W+1)'(1), {BIT_W{1'b0}}};
   end

   always_comb begin
      state_in          = state_ff;
      next_seq_in       = next_seq_ff;
      window_in         = window_ff;
      thresh_in         = thresh_ff;
      sent_in           = sent_ff;
      timed_out_in      = timed_out_ff;
      finished_in       = finished_ff;
      clr_row_in        = clr_row_ff;
      scan_row_in       = scan_row_ff;
      rsp_valid_in      = 1'b0;
      rsp_send_valid_in = 1'b0;
      rsp_send_seq_in   = '0;
      rsp_send_bytes_in = '0;
      ram_wr_en         = 1'b0;
      ram_wr_addr       = clr_row_ff;
      ram_wr_data       = '0;
      ram_rd_addr       = '0;
      remain            = '0;
      grown             = '0;
      half              = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en  = 1'b1;
            clr_row_in = clr_row_ff + ROW_W'(1);
            if (clr_row_ff == ROW_W'(ACK_ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            ram_rd_addr = req_ack_idx[BIT_W +: ROW_W];
            if (accept) begin
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            if (!finished_ff) begin
               unique case (cmd_ff)
                  CMD_SEND: begin
                     if (sent_ff < window_ff && next_seq_ff <= pkt_count_ff) begin
                        if ({1'b0, file_bytes_ff} > offset_ff) begin
                           remain = {1'b0, file_bytes_ff} - offset_ff;
                        end
                        rsp_send_valid_in = 1'b1;
                        rsp_send_seq_in   = next_seq_ff;
                        if (remain < (FILE_W+1)'(PACKET_BYTES)) begin
                           rsp_send_bytes_in = remain[BYTES_W-1:0];
                        end else begin
                           rsp_send_bytes_in = BYTES_W'(PACKET_BYTES);
                        end
                        next_seq_in = next_seq_ff + SEQ_W'(1);
                        sent_in     = sent_ff + WIN_W'(1);
                     end
                  end
                  CMD_ACK: begin
                     if (ack_in_range) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = ack_idx[BIT_W +: ROW_W];
                        ram_wr_data = ram_rd_data
                                      | (ACK_WORD_W'(1) << ack_idx[BIT_W-1:0]);
                     end
                  end
                  CMD_TIMEOUT: begin
                     half = window_ff[WIN_W-1:1];
                     if (half == '0) begin
                        half = THR_W'(1);
                     end
                     thresh_in    = half;
                     timed_out_in = 1'b1;
                  end
                  CMD_END: begin
                     timed_out_in = 1'b0;
                     sent_in      = '0;
                     if (!timed_out_ff) begin
                        if (window_ff < {1'b0, thresh_ff}) begin
                           grown = {window_ff, 1'b0};
                        end else begin
                           grown = {1'b0, window_ff} + (WIN_W+1)'(1);
                        end
                        if (grown > (WIN_W+1)'(MAX_WINDOW)) begin
                           grown = (WIN_W+1)'(MAX_WINDOW);
                        end
                        window_in = grown[WIN_W-1:0];
                     end else if (pkt_count_ff == '0) begin
                        finished_in = 1'b1;
                     end else begin
                        // go-back-N: look for the first hole in the bitmap
                        rsp_valid_in = 1'b0;
                        state_in     = ST_SCAN;
                        scan_row_in  = '0;
                        ram_rd_addr  = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            ram_rd_addr = scan_row_ff + ROW_W'(1);
            scan_row_in = scan_row_ff + ROW_W'(1);
            if (row_zeros != '0) begin
               next_seq_in  = SEQ_W'({scan_row_ff, first_bit}) + SEQ_W'(1);
               window_in    = WIN_W'(1);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (row_end >= pkt_count_ff) begin
               finished_in  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         next_seq_ff  <= SEQ_W'(1);
         window_ff    <= WIN_W'(1);
         thresh_ff    <= THR_W'(THRESH_RESET);
         sent_ff      <= '0;
         timed_out_ff <= 1'b0;
         finished_ff  <= 1'b0;
         clr_row_ff   <= '0;
         scan_row_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_seq_ff  <= next_seq_in;
         window_ff    <= window_in;
         thresh_ff    <= thresh_in;
         sent_ff      <= sent_in;
         timed_out_ff <= timed_out_in;
         finished_ff  <= finished_in;
         clr_row_ff   <= clr_row_in;
         scan_row_ff  <= scan_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item capture and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff     <= cmd_type'(req_cmd);
         ack_seq_ff <= req_ack_seq;
         offset_ff  <= (FILE_W+1)'(next_seq_ff - SEQ_W'(1)) * (FILE_W+1)'(PACKET_BYTES);
      end
      if (rsp_valid_in) begin
         rsp_send_valid_ff <= rsp_send_valid_in;
         rsp_send_seq_ff   <= rsp_send_seq_in;
         rsp_send_bytes_ff <= rsp_send_bytes_in;
      end
   end

   scwin_ram #(
      .WIDTH (ACK_WORD_W),
      .DEPTH (ACK_ROWS)
   ) u_ack_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_send_valid       = rsp_send_valid_ff;
   assign rsp_send_seq         = rsp_send_seq_ff;
   assign rsp_send_bytes       = rsp_send_bytes_ff;
   assign rsp_window_size      = window_ff;
   assign rsp_slow_start_limit = thresh_ff;
   assign rsp_resume_seq       = next_seq_ff;
   assign rsp_all_acked        = finished_ff;

   // ---------------------------------------------------------------- checks
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted item did not raise busy");

   a_single_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for two cycles");

   a_send_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_valid |-> rsp_send_seq != '0 && rsp_send_bytes != '0)
      else $error("granted slot with empty sequence or length");

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      finished_ff |=> finished_ff)
      else $error("transfer done flag dropped");

   a_window_nonzero: assert property (@(posedge clock) disable iff (reset)
      window_ff != '0 && thresh_ff != '0)
      else $error("window or threshold fell to zero");

endmodule

`default_nettype wire
